[rtl/hsv_pkg.sv]
// Package: constants, types and helpers for the HSV to RGB565 converter.
package hsv_pkg;

  localparam int HUE_FRAC_BITS = 6;

  localparam int HUE_W = 15;
  localparam int CH_W  = 8;
  localparam int PROD_W = 2 * CH_W;
  localparam int PIX_W = 16;

  localparam longint unsigned SEG_L    = 64'd60 << HUE_FRAC_BITS;
  localparam longint unsigned PERIOD_L = SEG_L * 6;
  localparam int SEG_W = $clog2(SEG_L + 1);

  localparam logic [HUE_W-1:0] HUE_PERIOD = HUE_W'(PERIOD_L);
  localparam logic [SEG_W-1:0] SEG = SEG_W'(SEG_L);

  localparam longint unsigned DEN_L = SEG_L * 255;
  localparam int DEN_W = $clog2(DEN_L);
  localparam int X_W = $clog2(DEN_L * 255 + 1);
  localparam int RECIP_SH = X_W + DEN_W;
  localparam int RECIP_W = X_W + 1;
  localparam int P_W = X_W + RECIP_W;
  localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SH) + DEN_L - 1) / DEN_L;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  localparam logic [2:0] SECT_RY = 3'd0;
  localparam logic [2:0] SECT_YG = 3'd1;
  localparam logic [2:0] SECT_GC = 3'd2;
  localparam logic [2:0] SECT_CB = 3'd3;
  localparam logic [2:0] SECT_BM = 3'd4;
  localparam logic [2:0] SECT_MR = 3'd5;

  typedef struct packed {
    logic [2:0]        sector;
    logic [SEG_W-1:0]  num;
    logic [PROD_W-1:0] chroma;
    logic [PROD_W-1:0] offset;
    logic [CH_W-1:0]   val;
  } front_t;

  typedef struct packed {
    logic [2:0]      sector;
    logic [CH_W-1:0] pc;
    logic [CH_W-1:0] sc;
    logic [CH_W-1:0] zc;
  } chan_t;

  function automatic logic [HUE_W-1:0] sector_base(input logic [2:0] sector);
    logic [HUE_W-1:0] base;
    case (sector)
      SECT_YG: base = HUE_W'(SEG_L);
      SECT_GC: base = HUE_W'(SEG_L * 2);
      SECT_CB: base = HUE_W'(SEG_L * 3);
      SECT_BM: base = HUE_W'(SEG_L * 4);
      SECT_MR: base = HUE_W'(SEG_L * 5);
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

[rtl/hsv_front.sv]
// Front stages: hue reduction, chroma and offset, sector and secondary weight.
module hsv_front
  import hsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  brightness,
  output logic             out_valid,
  output front_t           out_item
);

  logic              v1;
  logic [HUE_W-1:0]  h1;
  logic [PROD_W-1:0] chroma1;
  logic [PROD_W-1:0] offset1;
  logic [CH_W-1:0]   val1;

  logic              v2;
  logic [2:0]        sector2;
  logic [SEG_W-1:0]  frac2;
  logic [PROD_W-1:0] chroma2;
  logic [PROD_W-1:0] offset2;
  logic [CH_W-1:0]   val2;

  logic [2:0]        sector_next;
  logic [HUE_W-1:0]  frac_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    h1      <= (hue >= HUE_PERIOD) ? hue - HUE_PERIOD : hue;
    chroma1 <= PROD_W'(saturation) * PROD_W'(brightness);
    offset1 <= PROD_W'(brightness) * PROD_W'(8'hFF - saturation);
    val1    <= brightness;
  end

  always_comb begin
    priority if (h1 >= HUE_W'(SEG_L * 5)) begin
      sector_next = SECT_MR;
    end else if (h1 >= HUE_W'(SEG_L * 4)) begin
      sector_next = SECT_BM;
    end else if (h1 >= HUE_W'(SEG_L * 3)) begin
      sector_next = SECT_CB;
    end else if (h1 >= HUE_W'(SEG_L * 2)) begin
      sector_next = SECT_GC;
    end else if (h1 >= HUE_W'(SEG_L)) begin
      sector_next = SECT_YG;
    end else begin
      sector_next = SECT_RY;
    end
    frac_full = h1 - sector_base(sector_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sector2 <= sector_next;
    frac2   <= SEG_W'(frac_full);
    chroma2 <= chroma1;
    offset2 <= offset1;
    val2    <= val1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    out_item.sector <= sector2;
    out_item.num    <= sector2[0] ? SEG - frac2 : frac2;
    out_item.chroma <= chroma2;
    out_item.offset <= offset2;
    out_item.val    <= val2;
  end

endmodule

[rtl/hsv_scale.sv]
// Scale stages: weighted sums and division by the sector length times 255.
module hsv_scale
  import hsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  front_t in_item,
  output logic   out_valid,
  output chan_t  out_item
);

  logic            v4;
  logic [X_W-1:0]  xs4;
  logic [X_W-1:0]  xz4;
  logic [2:0]      sector4;
  logic [CH_W-1:0] val4;

  logic [P_W-1:0]  prod_s;
  logic [P_W-1:0]  prod_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= in_valid;
    end
    xs4 <= X_W'(in_item.chroma) * X_W'(in_item.num)
         + X_W'(in_item.offset) * X_W'(SEG);
    xz4 <= X_W'(in_item.offset) * X_W'(SEG);
    sector4 <= in_item.sector;
    val4    <= in_item.val;
  end

  assign prod_s = P_W'(xs4) * P_W'(RECIP);
  assign prod_z = P_W'(xz4) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_item.sector <= sector4;
    out_item.pc     <= val4;
    out_item.sc     <= CH_W'(prod_s >> RECIP_SH);
    out_item.zc     <= CH_W'(prod_z >> RECIP_SH);
  end

endmodule

[rtl/hsv_to_rgb565_converter.sv]
// Top level: HSV to byte-swapped RGB565 converter, six-stage pipeline.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   input    | start / busy     | hue[14:0], saturation[7:0], brightness[7:0]
//   result   | done (1 cycle)   | pixel[15:0]
//
// An item is taken at every edge with start high; busy is always low.
// Each pixel appears after its item has passed the stages in order, one per clock:
// hue and products, sector, weight, weighted sums, reciprocal multipliers,
// packing.
// rst clears the valid bits only; the receiver cannot stall the output.
module hsv_to_rgb565_converter
  import hsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  brightness,
  output logic             done,
  output logic [PIX_W-1:0] pixel
);

  logic       front_valid;
  front_t     front_item;
  logic       scale_valid;
  chan_t      scale_item;

  logic [CH_W-1:0]  r;
  logic [CH_W-1:0]  g;
  logic [CH_W-1:0]  b;
  logic [PIX_W-1:0] packed_px;

  assign busy = 1'b0;

  hsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (front_valid),
    .out_item   (front_item)
  );

  hsv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .out_valid (scale_valid),
    .out_item  (scale_item)
  );

  always_comb begin
    unique case (scale_item.sector)
      SECT_RY: begin
        r = scale_item.pc; g = scale_item.sc; b = scale_item.zc;
      end
      SECT_YG: begin
        r = scale_item.sc; g = scale_item.pc; b = scale_item.zc;
      end
      SECT_GC: begin
        r = scale_item.zc; g = scale_item.pc; b = scale_item.sc;
      end
      SECT_CB: begin
        r = scale_item.zc; g = scale_item.sc; b = scale_item.pc;
      end
      SECT_BM: begin
        r = scale_item.sc; g = scale_item.zc; b = scale_item.pc;
      end
      default: begin
        r = scale_item.pc; g = scale_item.zc; b = scale_item.sc;
      end
    endcase
    packed_px = {r[7:3], g[7:2], b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= scale_valid;
    end
    pixel <= {packed_px[7:0], packed_px[15:8]};
  end

endmodule
